@@ src/w3f_pkg.sv @@
// Shared types, constants and helper functions of the 3x3 window filter unit.
package w3f_pkg;

  localparam int PIX_BITS  = 8;
  localparam int NUM_PIX   = 9;
  localparam int OUT_BITS  = 19;
  localparam int SUM_BITS  = 12;   // nine pixels
  localparam int SQ_BITS   = 20;   // nine squared pixels
  localparam int VARD_BITS = 23;   // 9*sumsq - sum^2
  localparam int KSUM_BITS = 13;   // signed kernel sum
  localparam int MEAN_BITS = 12;   // round(16*sum/9)
  localparam int VAR_BITS  = 18;   // round(16*d/81)

  // Division by 9 and by 81 through reciprocal multiplication, exact over the value range
  localparam logic [15:0] MEAN_RECIP = 16'd58255;     // ceil(2^19 / 9)
  localparam int          MEAN_SHIFT = 19;
  localparam logic [25:0] VAR_RECIP  = 26'd53024288;  // ceil(2^32 / 81)
  localparam int          VAR_SHIFT  = 32;

  typedef logic [PIX_BITS-1:0] w3f_pix_t;
  typedef w3f_pix_t [NUM_PIX-1:0] w3f_window_t;   // index 0 top left, row-major

  typedef enum logic [1:0] {
    MODE_MEAN   = 2'd0,
    MODE_VAR    = 2'd1,
    MODE_MEDIAN = 2'd2,
    MODE_KERNEL = 2'd3
  } w3f_mode_t;

  typedef enum logic [2:0] {
    KSEL_ZERO    = 3'd0,
    KSEL_BOX     = 3'd1,
    KSEL_SHARPEN = 3'd2,
    KSEL_SOBEL_H = 3'd3,
    KSEL_SOBEL_V = 3'd4
  } w3f_ksel_t;

  localparam logic [2:0] KSEL_RESET = KSEL_BOX;

  // Pipeline advance strobes shared by the datapath modules
  typedef struct packed {
    logic load1;
    logic load2;
  } w3f_adv_t;

  typedef struct packed {
    w3f_pix_t lo;
    w3f_pix_t mid;
    w3f_pix_t hi;
  } w3f_trio_t;

  function automatic w3f_pix_t pix_min(input w3f_pix_t a, input w3f_pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic w3f_pix_t pix_max(input w3f_pix_t a, input w3f_pix_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic w3f_pix_t med3(input w3f_pix_t a, input w3f_pix_t b, input w3f_pix_t c);
    return pix_max(pix_min(a, b), pix_min(pix_max(a, b), c));
  endfunction

  function automatic w3f_trio_t sort3(input w3f_pix_t a, input w3f_pix_t b, input w3f_pix_t c);
    w3f_trio_t r;
    w3f_pix_t  x;
    w3f_pix_t  y;
    w3f_pix_t  t;
    x     = pix_min(a, b);
    y     = pix_max(a, b);
    r.lo  = pix_min(x, c);
    t     = pix_max(x, c);
    r.mid = pix_min(y, t);
    r.hi  = pix_max(y, t);
    return r;
  endfunction

endpackage

@@ src/w3f_stats.sv @@
// Mean and variance datapath: sums in stage one, mean reciprocal product and variance difference in stage two.
module w3f_stats (
  input  logic                               clk,
  input  w3f_pkg::w3f_adv_t                  adv,
  input  w3f_pkg::w3f_window_t               window,
  output logic [w3f_pkg::MEAN_BITS-1:0]      mean_q,
  output logic [w3f_pkg::VAR_BITS-1:0]       var_q
);
  import w3f_pkg::*;

  logic [SUM_BITS-1:0]  sum;
  logic [SUM_BITS-1:0]  sum_next;
  logic [SQ_BITS-1:0]   sumsq;
  logic [SQ_BITS-1:0]   sumsq_next;
  logic [VARD_BITS-1:0] var_d;
  logic [VARD_BITS-1:0] var_d_next;
  logic [31:0]          mean_prod;
  logic [31:0]          mean_prod_next;
  logic [23:0]          sum_sq;
  logic [15:0]          mean_n;
  logic [26:0]          var_n;
  logic [52:0]          var_prod;

  always_comb begin
    sum_next   = '0;
    sumsq_next = '0;
    for (int i = 0; i < NUM_PIX; i++) begin
      sum_next   = sum_next + SUM_BITS'(window[i]);
      sumsq_next = sumsq_next + SQ_BITS'(16'(window[i]) * 16'(window[i]));
    end
  end

  // 9*sumsq - sum^2 is never negative
  assign sum_sq         = 24'(sum) * 24'(sum);
  assign var_d_next     = VARD_BITS'(24'({sumsq, 3'b000}) + 24'(sumsq) - sum_sq);
  assign mean_n         = {sum, 4'b0000} + 16'd4;
  assign mean_prod_next = 32'(mean_n) * 32'(MEAN_RECIP);

  always_ff @(posedge clk) begin
    if (adv.load1) begin
      sum   <= sum_next;
      sumsq <= sumsq_next;
    end
    if (adv.load2) begin
      var_d     <= var_d_next;
      mean_prod <= mean_prod_next;
    end
  end

  assign var_n    = 27'({var_d, 4'b0000}) + 27'd40;
  assign var_prod = 53'(var_n) * 53'(VAR_RECIP);
  assign var_q    = VAR_BITS'(var_prod >> VAR_SHIFT);
  assign mean_q   = MEAN_BITS'(mean_prod >> MEAN_SHIFT);

endmodule

@@ src/w3f_median.sv @@
// Median of nine: row sorts in stage one, column selection and final pick in stage two.
module w3f_median (
  input  logic                  clk,
  input  w3f_pkg::w3f_adv_t     adv,
  input  w3f_pkg::w3f_window_t  window,
  output w3f_pkg::w3f_pix_t     med
);
  import w3f_pkg::*;

  w3f_trio_t row [3];
  w3f_trio_t row_next [3];
  w3f_pix_t  med_next;
  w3f_pix_t  lo_max;
  w3f_pix_t  mid_med;
  w3f_pix_t  hi_min;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      row_next[r] = sort3(window[3*r], window[3*r+1], window[3*r+2]);
    end
  end

  assign lo_max   = pix_max(pix_max(row[0].lo, row[1].lo), row[2].lo);
  assign hi_min   = pix_min(pix_min(row[0].hi, row[1].hi), row[2].hi);
  assign mid_med  = med3(row[0].mid, row[1].mid, row[2].mid);
  assign med_next = med3(lo_max, mid_med, hi_min);

  always_ff @(posedge clk) begin
    if (adv.load1) begin
      for (int r = 0; r < 3; r++) begin
        row[r] <= row_next[r];
      end
    end
    if (adv.load2) begin
      med <= med_next;
    end
  end

endmodule

@@ src/w3f_kernel.sv @@
// Weighted window sum under the selected fixed kernel, written as shift-add terms.
module w3f_kernel (
  input  logic                                clk,
  input  w3f_pkg::w3f_adv_t                   adv,
  input  w3f_pkg::w3f_window_t                window,
  input  logic [2:0]                          kernel_select,
  output logic signed [w3f_pkg::KSUM_BITS-1:0] ksum
);
  import w3f_pkg::*;

  logic signed [KSUM_BITS-1:0] px [NUM_PIX];
  logic signed [KSUM_BITS-1:0] box;
  logic signed [KSUM_BITS-1:0] ksum_next;
  logic signed [KSUM_BITS-1:0] ksum1;

  always_comb begin
    for (int i = 0; i < NUM_PIX; i++) begin
      px[i] = signed'(KSUM_BITS'(window[i]));
    end
  end

  assign box = px[0] + px[1] + px[2] + px[3] + px[4] + px[5] + px[6] + px[7] + px[8];

  always_comb begin
    unique case (kernel_select)
      KSEL_BOX:     ksum_next = box;
      // 9*centre minus the eight neighbours
      KSEL_SHARPEN: ksum_next = (px[4] <<< 3) + (px[4] <<< 1) - box;
      KSEL_SOBEL_H: ksum_next = (px[6] + (px[7] <<< 1) + px[8])
                              - (px[0] + (px[1] <<< 1) + px[2]);
      KSEL_SOBEL_V: ksum_next = (px[2] + (px[5] <<< 1) + px[8])
                              - (px[0] + (px[3] <<< 1) + px[6]);
      default:      ksum_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv.load1) begin
      ksum1 <= ksum_next;
    end
    if (adv.load2) begin
      ksum <= ksum1;
    end
  end

endmodule

@@ src/window_3x3_filter_unit_top.sv @@
// Top level of the 3x3 window filter unit: handshake, pipeline control and result select.
//
// One 3x3 window enters per clock and gives one result while the output side is not
// stalled. The path is four registers deep: input register, row sums and row sorts,
// products and median pick, output register; a result shows on m_axis_tvalid once its window
// is through all four. Each stage has its own valid bit and moves whenever the stage after
// it is free, so bubbles close up and windows are taken while a result waits. The mode
// (tuser) picks mean or variance, both with 4 fraction bits, the median, or the sum under
// the kernel chosen by kernel_select (0 zero, 1 box, 2 sharpen, 3 Sobel horizontal,
// 4 Sobel vertical, other codes give zero; reset value 1). Write kernel_select only while
// no window is in flight.
module window_3x3_filter_unit_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_wdata,       // kernel_select
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,    // pix_top_left .. pix_bot_right, 8 bits each
  input  logic [1:0]  s_axis_tuser,    // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata     // result_value[18:0], zeros above
);
  import w3f_pkg::*;

  logic [2:0]                  kernel_select;
  logic                        v0;
  logic                        v1;
  logic                        v2;
  logic                        vo;
  logic                        rdy0;
  logic                        rdy1;
  logic                        rdy2;
  logic                        rdy_o;
  logic                        load_o;
  w3f_adv_t                    adv;
  w3f_window_t                 window;
  w3f_mode_t                   mode0;
  w3f_mode_t                   mode1;
  w3f_mode_t                   mode2;
  logic [MEAN_BITS-1:0]        mean_q;
  logic [VAR_BITS-1:0]         var_q;
  w3f_pix_t                    med;
  logic signed [KSUM_BITS-1:0] ksum;
  logic [OUT_BITS-1:0]         result_value;
  logic [OUT_BITS-1:0]         result_value_next;

  // A stage moves when it is empty or the next stage moves
  assign rdy_o  = !vo || m_axis_tready;
  assign rdy2   = !v2 || rdy_o;
  assign rdy1   = !v1 || rdy2;
  assign rdy0   = !v0 || rdy1;
  assign adv.load1 = v0 && rdy1;
  assign adv.load2 = v1 && rdy2;
  assign load_o    = v2 && rdy_o;

  assign s_axis_tready = rdy0;
  assign m_axis_tvalid = vo;
  assign m_axis_tdata  = {5'b00000, result_value};

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_select <= KSEL_RESET;
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      vo <= 1'b0;
    end else begin
      if (cfg_we) begin
        kernel_select <= cfg_wdata;
      end
      if (rdy0)  v0 <= s_axis_tvalid;
      if (rdy1)  v1 <= v0;
      if (rdy2)  v2 <= v1;
      if (rdy_o) vo <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0 && s_axis_tvalid) begin
      window <= s_axis_tdata;
      mode0  <= w3f_mode_t'(s_axis_tuser);
    end
    if (adv.load1) mode1 <= mode0;
    if (adv.load2) mode2 <= mode1;
    if (load_o)    result_value <= result_value_next;
  end

  w3f_stats u_stats (
    .clk    (clk),
    .adv    (adv),
    .window (window),
    .mean_q (mean_q),
    .var_q  (var_q)
  );

  w3f_median u_median (
    .clk    (clk),
    .adv    (adv),
    .window (window),
    .med    (med)
  );

  w3f_kernel u_kernel (
    .clk           (clk),
    .adv           (adv),
    .window        (window),
    .kernel_select (kernel_select),
    .ksum          (ksum)
  );

  always_comb begin
    result_value_next = '0;
    case (mode2)
      MODE_MEAN:   result_value_next = OUT_BITS'(mean_q);
      MODE_VAR:    result_value_next = OUT_BITS'(var_q);
      MODE_MEDIAN: result_value_next = OUT_BITS'(med);
      MODE_KERNEL: result_value_next = OUT_BITS'(ksum);
    endcase
  end

  // A taken result frees every stage, so the input side must be open
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready) |-> s_axis_tready)
    else $error("input stalled while output drained");

  assert property (@(posedge clk) disable iff (rst)
    $rose(v1) |-> $past(v0))
    else $error("stage one filled from an empty input register");

  assert property (@(posedge clk) disable iff (rst)
    $rose(vo) |-> $past(v2))
    else $error("output filled from an empty stage two");

  assert property (@(posedge clk) disable iff (rst)
    (load_o && mode2 == MODE_VAR) |=> !result_value[OUT_BITS-1])
    else $error("variance result negative");

endmodule

@@ tb/window_result_checker.sv @@
// Result checker of the 3x3 window filter unit: predicts every result and compares it.
module window_result_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_wdata,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,
  output int          mismatches,
  output int          results_pending
);
  import w3f_pkg::*;

  logic [2:0]  kernel_sel;
  logic [23:0] expected_values[$];

  function automatic logic [18:0] filter_value(input logic [1:0] mode, input w3f_window_t win,
                                               input logic [2:0] ksel);
    int px[9];
    int sum;
    int sumsq;
    int acc;
    int t;
    int i;
    int j;
    sum   = 0;
    sumsq = 0;
    acc   = 0;
    for (i = 0; i < 9; i++) begin
      px[i] = int'(win[i]);
      sum   += px[i];
      sumsq += px[i] * px[i];
    end
    case (w3f_mode_t'(mode))
      MODE_MEAN:  acc = (16 * sum + 4) / 9;
      MODE_VAR:   acc = (16 * (9 * sumsq - sum * sum) + 40) / 81;
      MODE_MEDIAN: begin
        // insertion sort, then take the fifth smallest
        for (i = 1; i < 9; i++) begin
          t = px[i];
          j = i - 1;
          while (j >= 0 && px[j] > t) begin
            px[j + 1] = px[j];
            j--;
          end
          px[j + 1] = t;
        end
        acc = px[4];
      end
      default: begin
        case (ksel)
          KSEL_BOX:     acc = sum;
          KSEL_SHARPEN: acc = 10 * px[4] - sum;
          KSEL_SOBEL_H: acc = (px[6] + 2 * px[7] + px[8]) - (px[0] + 2 * px[1] + px[2]);
          KSEL_SOBEL_V: acc = (px[2] + 2 * px[5] + px[8]) - (px[0] + 2 * px[3] + px[6]);
          default:      acc = 0;  // zero kernel and codes without meaning
        endcase
      end
    endcase
    if (acc > 262143) acc = 262143;
    if (acc < -262144) acc = -262144;
    return acc[18:0];
  endfunction

  always @(posedge clk) begin
    logic [23:0] want;
    if (rst) begin
      kernel_sel = KSEL_BOX;
      expected_values.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) kernel_sel = cfg_wdata;
      // check the outgoing item before queueing the incoming one
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_values.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: got %h with nothing outstanding", m_axis_tdata);
        end else begin
          want = expected_values.pop_front();
          if (m_axis_tdata !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected %h, got %h", want, m_axis_tdata);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_values.push_back({5'd0, filter_value(s_axis_tuser, s_axis_tdata, kernel_sel)});
    end
    results_pending = expected_values.size();
  end

endmodule

@@ tb/tb_window_3x3_filter_unit_top.sv @@
// Testbench top of the 3x3 window filter unit: clock, reset, stimulus and verdict.
module tb_window_3x3_filter_unit_top;
  import w3f_pkg::*;

  localparam logic [2:0] KSEL_SPARE_LO  = 3'd5;
  localparam logic [2:0] KSEL_SPARE_MID = 3'd6;
  localparam logic [2:0] KSEL_SPARE_HI  = 3'd7;
  localparam int NUM_PHASES     = 10;
  localparam int ITEMS_PER_PHASE = 200;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;    // pix_top_left .. pix_bot_right, 8 bits each
  logic [1:0]  s_axis_tuser = '0;    // mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;         // result_value[18:0], zeros above
  logic        no_idle = 1'b0;
  int          mismatches;
  int          results_pending;

  always #6 clk = ~clk;

  window_3x3_filter_unit_top dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  window_result_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .mismatches      (mismatches),
    .results_pending (results_pending)
  );

  // stall the result side at random, except during the calm stretch
  always @(negedge clk) begin
    m_axis_tready <= rst ? 1'b0 : (no_idle || $urandom_range(0, 99) >= 17);
  end

  function automatic logic [2:0] phase_kernel(input int p);
    case (p)
      0: return KSEL_SHARPEN;
      1: return KSEL_SOBEL_H;
      2: return KSEL_SOBEL_V;
      3: return KSEL_ZERO;
      4: return KSEL_SPARE_LO;
      5: return KSEL_SPARE_MID;
      6: return KSEL_SPARE_HI;
      7: return KSEL_BOX;
      8: return KSEL_SOBEL_V;
      default: return KSEL_SOBEL_H;
    endcase
  endfunction

  // mostly uniform windows, some built from full-scale pixels in edge-like layouts
  function automatic w3f_window_t random_window();
    w3f_window_t win;
    int kind;
    int i;
    logic [7:0] lo;
    logic [7:0] hi;
    kind = $urandom_range(0, 9);
    lo   = $urandom_range(0, 1) ? 8'hff : 8'h00;
    hi   = ~lo;
    for (i = 0; i < 9; i++) begin
      win[i] = 8'($urandom_range(0, 255));
      case (kind)
        6: win[i] = $urandom_range(0, 1) ? 8'hff : 8'h00;
        7: if (i / 3 != 1) win[i] = (i / 3 == 0) ? lo : hi;
        8: if (i % 3 != 1) win[i] = (i % 3 == 0) ? lo : hi;
        9: win[i] = (i == 4) ? lo : hi;
        default: ;
      endcase
    end
    return win;
  endfunction

  // call at a falling edge; returns at the falling edge after the item is taken
  task automatic send_window(input logic [1:0] mode, input w3f_window_t win);
    if (!no_idle) begin
      while ($urandom_range(0, 99) < 17) begin
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= win;
    s_axis_tuser  <= mode;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_pipeline();
    s_axis_tvalid <= 1'b0;
    while (results_pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    w3f_window_t win;
    int m;
    int k;
    int p;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset kernel (box): flat, checkerboard, lone centre and ring windows in every mode
    for (m = 0; m < 4; m++) begin
      for (k = 0; k < 5; k++) begin
        case (k)
          0: win = '0;
          1: win = '1;
          2: win = {8'hff, 8'h00, 8'hff, 8'h00, 8'hff, 8'h00, 8'hff, 8'h00, 8'hff};
          3: begin win = '0; win[4] = 8'hff; end
          default: begin win = '1; win[4] = 8'h00; end
        endcase
        send_window(m[1:0], win);
      end
    end

    for (p = 0; p < NUM_PHASES; p++) begin
      drain_pipeline();
      cfg_we    <= 1'b1;
      cfg_wdata <= phase_kernel(p);
      @(negedge clk);
      cfg_we  <= 1'b0;
      no_idle = (p == 5);
      for (k = 0; k < ITEMS_PER_PHASE; k++)
        send_window(2'($urandom_range(0, 3)), random_window());
    end
    no_idle = 1'b0;

    drain_pipeline();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && results_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

@@ window_3x3_filter_unit_top.f @@
src/w3f_pkg.sv
src/w3f_stats.sv
src/w3f_median.sv
src/w3f_kernel.sv
src/window_3x3_filter_unit_top.sv
tb/window_result_checker.sv
tb/tb_window_3x3_filter_unit_top.sv
